FILE: rtl/pbdbt_pkg.sv
`timescale 1ns / 1ps

package pbdbt_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int CMP_W       = 32;

  localparam int DEBOUNCE_W = 11;
  localparam int TIMEOUT_W  = 22;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_LIMIT = 11'd2000;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_LIMIT  = 22'd3600000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 11'd150;
  localparam logic [LEVEL_W-1:0]    LEVEL_RESET    = 8'd128;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE        = 2'd0,
    OP_RESTART       = 2'd1,
    OP_BACKLIGHT_ON  = 2'd2,
    OP_BACKLIGHT_OFF = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic        enter_pin;
    logic        up_pin;
    logic        down_pin;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic               enter_press;
    logic               up_press;
    logic               down_press;
    logic               any_press;
    logic [LEVEL_W-1:0] backlight_duty;
    logic               timeout_expired;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

FILE: rtl/pbdbt_chan.sv
`timescale 1ns / 1ps

interface pbdbt_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/panel_button_debounce_backlight_timer.sv
`timescale 1ns / 1ps

// Button debounce and backlight timer for a three-button panel. One request
// is taken every clock unless the input register is held by a stalled result
// register. A request lands in the input register and its result then in the
// output register, which holds while the result side stalls; meanwhile a new
// request is taken only into an empty input register. All time differences are
// taken on the low TIME_BITS of now_ms with wraparound. Configuration writes
// are taken every cycle and are meant to be made while no request is in
// flight; out-of-range debounce or timeout values are dropped.
module panel_button_debounce_backlight_timer #(
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  pbdbt_chan.sink   sample,
  pbdbt_chan.source result,
  pbdbt_chan.sink   cfg
);

  localparam int NB = pbdbt_pkg::NUM_BUTTONS;
  localparam int CW = pbdbt_pkg::CMP_W;

  // configuration registers
  logic [pbdbt_pkg::DEBOUNCE_W-1:0] debounce_ms;
  logic [pbdbt_pkg::TIMEOUT_W-1:0]  timeout_ms;
  logic [pbdbt_pkg::LEVEL_W-1:0]    backlight_level;

  logic [pbdbt_pkg::DEBOUNCE_W-1:0] cfg_deb;
  logic [pbdbt_pkg::TIMEOUT_W-1:0]  cfg_tmo;

  assign cfg.ready = 1'b1;
  assign cfg_deb   = cfg.data.data[pbdbt_pkg::DEBOUNCE_W-1:0];
  assign cfg_tmo   = cfg.data.data[pbdbt_pkg::TIMEOUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= pbdbt_pkg::DEBOUNCE_RESET;
      timeout_ms      <= '0;
      backlight_level <= pbdbt_pkg::LEVEL_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        pbdbt_pkg::REG_DEBOUNCE: begin
          if (cfg_deb != '0 && cfg_deb < pbdbt_pkg::DEBOUNCE_LIMIT) begin
            debounce_ms <= cfg_deb;
          end
        end
        pbdbt_pkg::REG_TIMEOUT: begin
          if (cfg_tmo <= pbdbt_pkg::TIMEOUT_LIMIT) begin
            timeout_ms <= cfg_tmo;
          end
        end
        pbdbt_pkg::REG_LEVEL: begin
          backlight_level <= cfg.data.data[pbdbt_pkg::LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input register
  logic             s1_valid;
  pbdbt_pkg::item_t s1;
  logic             advance;

  assign advance      = !result.valid || result.ready;
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1 <= sample.data;
    end
  end

  // button and backlight state
  logic [NB-1:0]                 prior_pressed, prior_pressed_next;
  logic [NB-1:0]                 press_flags, press_flags_next;
  logic [TIME_BITS-1:0]          release_time [NB];
  logic [TIME_BITS-1:0]          release_time_next [NB];
  logic [TIME_BITS-1:0]          activity_mark, activity_mark_next;
  logic [pbdbt_pkg::LEVEL_W-1:0] backlight_drive, backlight_drive_next;

  logic [TIME_BITS-1:0] now_t;
  logic [NB-1:0]        pressed;
  logic [TIME_BITS-1:0] rel_elapsed [NB];
  logic [TIME_BITS-1:0] act_elapsed;
  logic [TIME_BITS-1:0] exp_elapsed;
  logic                 expired;

  assign now_t   = s1.now_ms[TIME_BITS-1:0];
  assign pressed = {!s1.down_pin, !s1.up_pin, !s1.enter_pin};

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      rel_elapsed[i] = now_t - release_time[i];
    end
  end

  // with a button held the mark becomes now, so the elapsed time is zero
  assign act_elapsed = (|pressed) ? '0 : (now_t - activity_mark);

  always_comb begin
    prior_pressed_next   = prior_pressed;
    press_flags_next     = press_flags;
    release_time_next    = release_time;
    activity_mark_next   = activity_mark;
    backlight_drive_next = backlight_drive;
    case (s1.operation)
      pbdbt_pkg::OP_SAMPLE: begin
        if (timeout_ms != '0) begin
          if (|pressed) begin
            activity_mark_next = now_t;
          end
          backlight_drive_next = (CW'(act_elapsed) < CW'(timeout_ms)) ?
                                 backlight_level : '0;
        end
        for (int i = 0; i < NB; i++) begin
          press_flags_next[i] = 1'b0;
          if (!pressed[i] && prior_pressed[i]) begin
            press_flags_next[i]  = CW'(rel_elapsed[i]) > CW'(debounce_ms);
            release_time_next[i] = now_t;
          end
          prior_pressed_next[i] = pressed[i];
        end
      end
      pbdbt_pkg::OP_RESTART: begin
        activity_mark_next = now_t;
      end
      pbdbt_pkg::OP_BACKLIGHT_ON: begin
        backlight_drive_next = backlight_level;
      end
      pbdbt_pkg::OP_BACKLIGHT_OFF: begin
        backlight_drive_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign exp_elapsed = now_t - activity_mark_next;
  assign expired     = CW'(exp_elapsed) > CW'(timeout_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_pressed   <= '0;
      press_flags     <= '0;
      activity_mark   <= '0;
      backlight_drive <= '0;
      for (int i = 0; i < NB; i++) begin
        release_time[i] <= '0;
      end
    end else if (s1_valid && advance) begin
      prior_pressed   <= prior_pressed_next;
      press_flags     <= press_flags_next;
      activity_mark   <= activity_mark_next;
      backlight_drive <= backlight_drive_next;
      release_time    <= release_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      result.data.enter_press     <= press_flags_next[0];
      result.data.up_press        <= press_flags_next[1];
      result.data.down_press      <= press_flags_next[2];
      result.data.any_press       <= |press_flags_next;
      result.data.backlight_duty  <= backlight_drive_next;
      result.data.timeout_expired <= expired;
    end
  end

  // checks
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input register dropped a request while stalled");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s1_valid))
    else $error("result appeared without a request in the input register");

  a_any_press: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.any_press ==
      (result.data.enter_press || result.data.up_press || result.data.down_press))
    else $error("any_press does not match the press flags");

  a_debounce_range: assert property (@(posedge clk) disable iff (rst)
    debounce_ms != '0 && debounce_ms < pbdbt_pkg::DEBOUNCE_LIMIT)
    else $error("debounce register out of range");

  a_timeout_range: assert property (@(posedge clk) disable iff (rst)
    timeout_ms <= pbdbt_pkg::TIMEOUT_LIMIT)
    else $error("timeout register out of range");

endmodule
